// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is asserted.
`define FYS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("shuffle engine assertion failed");

// Clocked property, checked during reset as well.
`define FYS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shuffle engine assertion failed");

`endif

// ===== design/fys_pkg.sv =====
// ----------------------------------------------------------------------------
// fys_pkg
// Types and constants of the Fisher-Yates shuffle engine.
// ----------------------------------------------------------------------------
package fys_pkg;

    localparam int PERM_CAPACITY = 32;
    localparam int ADDR_W        = $clog2(PERM_CAPACITY);
    localparam int CUR_W         = $clog2(PERM_CAPACITY + 1);
    localparam int RND_W         = 32;
    localparam int CNT_W         = $clog2(RND_W);
    localparam int LEN_W         = 6;
    localparam int POS_W         = 5;
    localparam int ELEM_W        = 5;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    // Register word index, taken from paddr[2].
    localparam logic REG_PERM_LENGTH = 1'b0;

    typedef struct packed {
        logic [RND_W-1:0] random_word;
        logic             restart;
    } in_item_t;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [ELEM_W-1:0] element;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic              clear;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr_a;
        logic [ADDR_W-1:0] rd_addr_b;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] wr_data;
    } ram_req_t;

    typedef struct packed {
        logic             start;
        logic [RND_W-1:0] dividend;
        logic [CUR_W-1:0] divisor;
    } mod_req_t;

endpackage

// ===== design/fys_mod_unit.sv =====
// ----------------------------------------------------------------------------
// fys_mod_unit
// Bit-serial restoring remainder: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module fys_mod_unit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  fys_pkg::mod_req_t        req,
    output logic                     done,
    output logic [fys_pkg::CUR_W-1:0] remainder
);

    logic [fys_pkg::RND_W-1:0] dvd_reg, dvd_next;
    logic [fys_pkg::CUR_W-1:0] div_reg, div_next;
    logic [fys_pkg::CUR_W-1:0] rem_reg, rem_next;
    logic [fys_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [fys_pkg::CUR_W:0]   trial;

    always_comb begin
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[fys_pkg::RND_W-1]};
        if (req.start) begin
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in the next bit, subtract when it fits
            if (trial >= {1'b0, div_reg}) begin
                rem_next = fys_pkg::CUR_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = fys_pkg::CUR_W'(trial);
            end
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fys_pkg::CNT_W'(fys_pkg::RND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== design/fys_perm_ram.sv =====
// ----------------------------------------------------------------------------
// fys_perm_ram
// Permutation store: one write port, two registered read ports, and one
// valid bit per entry so that an unwritten entry reads as its own index.
// ----------------------------------------------------------------------------
module fys_perm_ram (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fys_pkg::ram_req_t          req,
    output logic [fys_pkg::ADDR_W-1:0] rd_data_a,
    output logic [fys_pkg::ADDR_W-1:0] rd_data_b
);

    logic [fys_pkg::ADDR_W-1:0]        mem_reg [fys_pkg::PERM_CAPACITY];
    logic [fys_pkg::PERM_CAPACITY-1:0] valid_reg;
    logic [fys_pkg::ADDR_W-1:0]        rd_a_reg;
    logic [fys_pkg::ADDR_W-1:0]        rd_b_reg;

    // clear on reset or restart: every entry falls back to identity
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_a_reg <= valid_reg[req.rd_addr_a] ? mem_reg[req.rd_addr_a] : req.rd_addr_a;
            rd_b_reg <= valid_reg[req.rd_addr_b] ? mem_reg[req.rd_addr_b] : req.rd_addr_b;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== design/fisher_yates_shuffle_engine.sv =====
// ----------------------------------------------------------------------------
// fisher_yates_shuffle_engine
// Descending Fisher-Yates shuffle over a small permutation store.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  s_      | in        | s_valid / s_ready    | random_word, restart
//  m_      | out       | m_valid / m_ready    | position, element, last
//  apb     | in        | psel, penable, pwrite | perm_length at byte 0
//
//  A swapping transaction runs the bit-serial remainder, then a two-port
//  read, two writes and the result slot.
//  The final transaction (cursor of two) then reads entry 0 for a second result.
//  A transaction while done, or with a cursor of zero, is taken with no result.
//  Reset is synchronous, active low; it clears the store's valid bits at once,
//  so the store reads as identity with no clearing pass.
//  A stalled m_ready holds the sequencer before it loads the result register.
// ----------------------------------------------------------------------------
module fisher_yates_shuffle_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input transactions
    input  logic                        s_valid,
    output logic                        s_ready,
    input  fys_pkg::in_item_t           s_data,
    // result transactions
    output logic                        m_valid,
    input  logic                        m_ready,
    output fys_pkg::out_item_t          m_data,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fys_pkg::APB_AW-1:0]  paddr,
    input  logic [fys_pkg::APB_DW-1:0]  pwdata,
    output logic [fys_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD   = 3'd1;
    localparam logic [2:0] ST_RDSW  = 3'd2;
    localparam logic [2:0] ST_WR1   = 3'd3;
    localparam logic [2:0] ST_WR2   = 3'd4;
    localparam logic [2:0] ST_EMIT1 = 3'd5;
    localparam logic [2:0] ST_RD0   = 3'd6;
    localparam logic [2:0] ST_EMIT0 = 3'd7;

    logic [2:0]                 state_reg, state_next;
    logic [fys_pkg::CUR_W-1:0]  cursor_reg, cursor_next;
    logic                       done_reg, done_next;
    logic [fys_pkg::LEN_W-1:0]  perm_length_reg, perm_length_next;
    logic [fys_pkg::ADDR_W-1:0] top_reg, top_next;
    logic [fys_pkg::ADDR_W-1:0] j_reg, j_next;
    logic [fys_pkg::ADDR_W-1:0] a_val_reg, a_val_next;
    logic [fys_pkg::ADDR_W-1:0] b_val_reg, b_val_next;
    logic                       m_valid_reg, m_valid_next;
    fys_pkg::out_item_t         m_data_reg, m_data_next;

    fys_pkg::ram_req_t          ram_req;
    fys_pkg::mod_req_t          mod_req;
    logic [fys_pkg::ADDR_W-1:0] rd_data_a;
    logic [fys_pkg::ADDR_W-1:0] rd_data_b;
    logic                       mod_done;
    logic [fys_pkg::CUR_W-1:0]  mod_rem;

    logic                       s_fire;
    logic                       out_free;
    logic                       cfg_write;
    logic [fys_pkg::CUR_W-1:0]  len_sat;
    logic [fys_pkg::CUR_W-1:0]  cursor_eff;
    logic                       done_eff;

    fys_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (mod_req),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    fys_perm_ram u_ram (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (ram_req),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // ---- configuration port ----
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        perm_length_next = perm_length_reg;
        if (cfg_write && (paddr[2] == fys_pkg::REG_PERM_LENGTH)) begin
            perm_length_next = pwdata[fys_pkg::LEN_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == fys_pkg::REG_PERM_LENGTH) begin
            prdata = fys_pkg::APB_DW'(perm_length_reg);
        end
    end

    // ---- input side ----
    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    // the result register is free when empty or once its transaction leaves this cycle
    assign out_free = !m_valid_reg || m_ready;

    // saturate the length to the store capacity at restart
    assign len_sat = (32'(perm_length_reg) > 32'(fys_pkg::PERM_CAPACITY))
                   ? fys_pkg::CUR_W'(fys_pkg::PERM_CAPACITY)
                   : fys_pkg::CUR_W'(perm_length_reg);

    assign cursor_eff = s_data.restart ? len_sat : cursor_reg;
    assign done_eff   = s_data.restart ? 1'b0 : done_reg;

    // ---- sequencer ----
    always_comb begin
        state_next   = state_reg;
        cursor_next  = cursor_reg;
        done_next    = done_reg;
        top_next     = top_reg;
        j_next       = j_reg;
        a_val_next   = a_val_reg;
        b_val_next   = b_val_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        ram_req      = '0;
        mod_req      = '0;
        mod_req.dividend = s_data.random_word;
        mod_req.divisor  = cursor_eff;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    // restart: drop every stored swap, back to identity
                    ram_req.clear = s_data.restart;
                    cursor_next   = cursor_eff;
                    done_next     = done_eff;
                    top_next      = fys_pkg::ADDR_W'(cursor_eff - 1'b1);
                    if (!done_eff) begin
                        if (cursor_eff >= fys_pkg::CUR_W'(2)) begin
                            mod_req.start = 1'b1;
                            state_next    = ST_MOD;
                        end else if (cursor_eff == fys_pkg::CUR_W'(1)) begin
                            state_next = ST_RD0;
                        end else begin
                            done_next = 1'b1;
                        end
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    j_next     = fys_pkg::ADDR_W'(mod_rem);
                    state_next = ST_RDSW;
                end
            end
            ST_RDSW: begin
                ram_req.rd_en     = 1'b1;
                ram_req.rd_addr_a = top_reg;
                ram_req.rd_addr_b = j_reg;
                state_next        = ST_WR1;
            end
            ST_WR1: begin
                a_val_next      = rd_data_a;
                b_val_next      = rd_data_b;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = top_reg;
                ram_req.wr_data = rd_data_b;
                state_next      = ST_WR2;
            end
            ST_WR2: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = j_reg;
                ram_req.wr_data = a_val_reg;
                state_next      = ST_EMIT1;
            end
            ST_EMIT1: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.position = fys_pkg::POS_W'(top_reg);
                    m_data_next.element  = fys_pkg::ELEM_W'(b_val_reg);
                    m_data_next.last     = 1'b0;
                    cursor_next          = cursor_reg - 1'b1;
                    if (cursor_reg == fys_pkg::CUR_W'(2)) begin
                        state_next = ST_RD0;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD0: begin
                ram_req.rd_en     = 1'b1;
                ram_req.rd_addr_a = '0;
                ram_req.rd_addr_b = '0;
                state_next        = ST_EMIT0;
            end
            ST_EMIT0: begin
                // read data holds: no other read is issued meanwhile
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.position = '0;
                    m_data_next.element  = fys_pkg::ELEM_W'(rd_data_a);
                    m_data_next.last     = 1'b1;
                    cursor_next          = '0;
                    done_next            = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cursor_reg      <= '0;
            done_reg        <= 1'b1;
            perm_length_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            done_reg        <= done_next;
            perm_length_reg <= perm_length_next;
            m_valid_reg     <= m_valid_next;
        end
        top_reg    <= top_next;
        j_reg      <= j_next;
        a_val_reg  <= a_val_next;
        b_val_reg  <= b_val_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/fys_checker.sv =====
// ----------------------------------------------------------------------------
// fys_checker
// Port-level checks of the shuffle engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fys_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input fys_pkg::out_item_t         m_data
);

    // a stalled result transaction holds
    `FYS_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data))

    // only position zero closes a permutation
    `FYS_ASSERT(a_last_pos0, aclk, aresetn, m_valid && m_data.last |-> m_data.position == 0)

    // position zero never appears without last
    `FYS_ASSERT(a_pos0_last, aclk, aresetn, m_valid && m_data.position == 0 |-> m_data.last)

    // reset empties the result register
    `FYS_ASSERT_ALWAYS(a_rst_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind fisher_yates_shuffle_engine fys_checker u_fys_checker (.*);
